@@ hdl/efa_pkg.sv @@
package efa_pkg;

  // field widths
  localparam int TS_W       = 48;
  localparam int POS_W      = 9;
  localparam int DIM_W      = 10;
  localparam int DRIFT_W    = 24;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_ROW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_COL   = 3'd5;

  localparam logic [DIM_W-1:0] NUM_ROWS_RST    = 10'd240;
  localparam logic [DIM_W-1:0] NUM_COLS_RST    = 10'd180;
  localparam logic [TS_W-1:0]  SLICE_WIDTH_RST = 48'd10000000;

  localparam logic OP_READ = 1'b1;

  // queue entry kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_ACC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO = 2'd2;

  // shift arithmetic: divide |dt*drift| by 10000 * 2^16
  localparam int TIME_DIV    = 10000;
  localparam int Q_FRAC      = 16;
  localparam int PROD_W      = 72;
  localparam int P_KEEP_W    = 40;
  localparam int P16_W       = P_KEEP_W - Q_FRAC;
  localparam int RECIP_SHIFT = 37;
  localparam logic [P16_W-1:0] RECIP = 24'd13743896;  // ceil(2^37 / 10000)
  localparam int K_W         = 10;
  // shift of 1024 pixels or more is always out of range
  localparam logic [P16_W-1:0] P16_LIMIT = 24'd10240000;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [DIM_W-1:0]   num_rows;
    logic [DIM_W-1:0]   num_cols;
    logic [TS_W-1:0]    slice_start;
    logic [TS_W-1:0]    slice_width;
    logic [DRIFT_W-1:0] drift_row;
    logic [DRIFT_W-1:0] drift_col;
  } cfg_t;

endpackage

@@ hdl/efa_queue.sv @@
module efa_queue #(
  parameter int DATA_W = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [DATA_W-1:0]              push_data,
  input  logic                           pop,
  output logic [DATA_W-1:0]              head,
  output logic                           not_empty,
  output logic [efa_pkg::FIFO_CNT_W-1:0] count
);

  logic [DATA_W-1:0]              slots [efa_pkg::FIFO_DEPTH];
  logic [efa_pkg::FIFO_PTR_W-1:0] wptr;
  logic [efa_pkg::FIFO_PTR_W-1:0] rptr;

  assign head      = slots[rptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  // front reserves room before it takes an item, so the queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < efa_pkg::FIFO_CNT_W'(efa_pkg::FIFO_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

@@ hdl/efa_front.sv @@
module efa_front #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  efa_pkg::cfg_t                  cfg,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           opcode,
  input  logic [efa_pkg::POS_W-1:0]      row,
  input  logic [efa_pkg::POS_W-1:0]      col,
  input  logic [efa_pkg::TS_W-1:0]       timestamp,
  input  logic                           clearing,
  input  logic [efa_pkg::FIFO_CNT_W-1:0] fifo_count,
  output logic                           push,
  output logic [efa_pkg::KIND_W+$clog2(MAX_ROWS*MAX_COLS)-1:0] push_data
);

  localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
  localparam int OCC_W  = efa_pkg::FIFO_CNT_W + 1;
  localparam int Q_W    = efa_pkg::POS_W + 2;

  // lane 0 is the row, lane 1 the column
  logic [1:0][efa_pkg::DRIFT_W-1:0] mag;
  logic [1:0]                       neg;
  logic [1:0][efa_pkg::DIM_W-1:0]   bound;

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  logic s1_op, s2_op, s3_op, s4_op, s5_op, s6_op;
  logic s2_win, s3_win, s4_win, s5_win, s6_win;
  logic [1:0][efa_pkg::POS_W-1:0] s1_pos, s2_pos, s3_pos, s4_pos, s5_pos, s6_pos;
  logic [efa_pkg::TS_W-1:0] s1_ts;
  logic [efa_pkg::TS_W-1:0] s2_dt;

  logic [1:0][2*efa_pkg::DRIFT_W-1:0] s3_lo, s3_hi;
  logic [1:0][efa_pkg::P_KEEP_W-1:0]  s4_p;
  logic [1:0]                         s4_big;
  logic [1:0][2*efa_pkg::P16_W-1:0]   s5_prod;
  logic [1:0][efa_pkg::P16_W-1:0]     s5_p16;
  logic [1:0]                         s5_lnz, s5_big;
  logic [1:0][Q_W:0]                  s6_d;     // signed pos - k
  logic [1:0][Q_W-1:0]                s6_s;     // pos + k
  logic [1:0]                         s6_rnz, s6_big;

  logic [efa_pkg::KIND_W-1:0] s7_kind;
  logic [Q_W-1:0]             s7_qr, s7_qc;

  logic [efa_pkg::TS_W:0]             diff;
  logic                               win;
  logic [1:0][efa_pkg::PROD_W-1:0]    psum;
  logic [1:0][efa_pkg::P16_W-1:0]     p16;
  logic [1:0][efa_pkg::K_W-1:0]       k6;
  logic [1:0][efa_pkg::P16_W-1:0]     rem6;
  logic [1:0][Q_W-1:0]                q7;
  logic [1:0]                         ok7;
  logic                               in_store;
  logic                               keep7;
  logic [efa_pkg::KIND_W-1:0]         kind7;
  logic [OCC_W-1:0]                   occ;

  assign bound[0] = cfg.num_rows;
  assign bound[1] = cfg.num_cols;
  assign neg[0]   = cfg.drift_row[efa_pkg::DRIFT_W-1];
  assign neg[1]   = cfg.drift_col[efa_pkg::DRIFT_W-1];
  assign mag[0]   = neg[0] ? (~cfg.drift_row + 1'b1) : cfg.drift_row;
  assign mag[1]   = neg[1] ? (~cfg.drift_col + 1'b1) : cfg.drift_col;

  // every item in the pipe has a queue slot reserved
  assign occ = OCC_W'(fifo_count) +
               OCC_W'($countones({s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v}));
  assign req_stall = clearing || (occ >= OCC_W'(efa_pkg::FIFO_DEPTH));

  // window test: start < ts <= start + width
  always_comb begin
    diff = {1'b0, s1_ts} - {1'b0, cfg.slice_start};
    win  = !diff[efa_pkg::TS_W] && (diff[efa_pkg::TS_W-1:0] != '0) &&
           (diff[efa_pkg::TS_W-1:0] <= cfg.slice_width);
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      psum[i] = {{efa_pkg::DRIFT_W{1'b0}}, s3_lo[i]} +
                {s3_hi[i], {efa_pkg::DRIFT_W{1'b0}}};
      p16[i]  = s4_p[i][efa_pkg::P_KEEP_W-1:efa_pkg::Q_FRAC];
      k6[i]   = s5_prod[i][efa_pkg::RECIP_SHIFT +: efa_pkg::K_W];
      rem6[i] = s5_p16[i] -
                efa_pkg::P16_W'(k6[i]) * efa_pkg::P16_W'(efa_pkg::TIME_DIV);
    end
  end

  // truncation toward zero: a positive drift with a remainder lands one lower,
  // except a shift that ends in (-1,0) which still gives pixel zero
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q7[i]  = '0;
      ok7[i] = 1'b0;
      if (neg[i]) begin
        q7[i]  = s6_s[i];
        ok7[i] = !s6_big[i];
      end else if (s6_d[i][Q_W]) begin
        ok7[i] = 1'b0;
      end else if (s6_d[i] == '0) begin
        ok7[i] = !s6_big[i];
      end else begin
        q7[i]  = s6_d[i][Q_W-1:0] - Q_W'(s6_rnz[i]);
        ok7[i] = !s6_big[i];
      end
      ok7[i] = ok7[i] && (q7[i] < Q_W'(bound[i]));
    end
    ok7[0] = ok7[0] && (32'(q7[0]) < MAX_ROWS);
    ok7[1] = ok7[1] && (32'(q7[1]) < MAX_COLS);
    in_store = (32'(s6_pos[0]) < MAX_ROWS) && (32'(s6_pos[1]) < MAX_COLS);
    if (s6_op == efa_pkg::OP_READ) begin
      keep7 = 1'b1;
      kind7 = in_store ? efa_pkg::KIND_READ : efa_pkg::KIND_ZERO;
    end else begin
      keep7 = s6_win && ok7[0] && ok7[1];
      kind7 = efa_pkg::KIND_ACC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
    end else begin
      s1_v <= req_valid && !req_stall;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v && keep7;
    end
  end

  always_ff @(posedge clk) begin
    s1_op     <= opcode;
    s1_pos[0] <= row;
    s1_pos[1] <= col;
    s1_ts     <= timestamp;

    s2_op  <= s1_op;
    s2_pos <= s1_pos;
    s2_win <= win;
    s2_dt  <= diff[efa_pkg::TS_W-1:0];

    s3_op  <= s2_op;
    s3_pos <= s2_pos;
    s3_win <= s2_win;
    s4_op  <= s3_op;
    s4_pos <= s3_pos;
    s4_win <= s3_win;
    s5_op  <= s4_op;
    s5_pos <= s4_pos;
    s5_win <= s4_win;
    s6_op  <= s5_op;
    s6_pos <= s5_pos;
    s6_win <= s5_win;

    for (int i = 0; i < 2; i++) begin
      s3_lo[i]   <= s2_dt[efa_pkg::DRIFT_W-1:0] * mag[i];
      s3_hi[i]   <= s2_dt[efa_pkg::TS_W-1:efa_pkg::DRIFT_W] * mag[i];
      s4_p[i]    <= psum[i][efa_pkg::P_KEEP_W-1:0];
      s4_big[i]  <= |psum[i][efa_pkg::PROD_W-1:efa_pkg::P_KEEP_W];
      s5_prod[i] <= p16[i] * efa_pkg::RECIP;
      s5_p16[i]  <= p16[i];
      s5_lnz[i]  <= |s4_p[i][efa_pkg::Q_FRAC-1:0];
      s5_big[i]  <= s4_big[i] || (p16[i] >= efa_pkg::P16_LIMIT);
      s6_rnz[i]  <= s5_lnz[i] || (rem6[i] != '0);
      s6_big[i]  <= s5_big[i];
      s6_d[i]    <= {3'b000, s5_pos[i]} - {2'b00, k6[i]};
      s6_s[i]    <= {2'b00, s5_pos[i]} + {1'b0, k6[i]};
    end

    s7_kind <= kind7;
    if (kind7 == efa_pkg::KIND_READ) begin
      s7_qr <= Q_W'(s6_pos[0]);
      s7_qc <= Q_W'(s6_pos[1]);
    end else if (kind7 == efa_pkg::KIND_ACC) begin
      s7_qr <= q7[0];
      s7_qc <= q7[1];
    end else begin
      s7_qr <= '0;
      s7_qc <= '0;
    end
  end

  assign push      = s7_v;
  assign push_data = {s7_kind,
                      ADDR_W'(s7_qr) * ADDR_W'(MAX_COLS) + ADDR_W'(s7_qc)};

endmodule

@@ hdl/efa_back.sv @@
module efa_back #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  logic [efa_pkg::KIND_W+$clog2(MAX_ROWS*MAX_COLS)-1:0] q_head,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [efa_pkg::CNT_W-1:0]   pixel_count
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [efa_pkg::CNT_W-1:0] counts [DEPTH];

  logic [ADDR_W-1:0]          clr_addr;
  logic                       adv;
  logic [efa_pkg::KIND_W-1:0] h_kind;
  logic [ADDR_W-1:0]          h_addr;

  logic                       b1_v;
  logic [efa_pkg::KIND_W-1:0] b1_kind;
  logic [ADDR_W-1:0]          b1_addr;
  logic [efa_pkg::CNT_W-1:0]  rd_data;

  logic                       last_v;
  logic [ADDR_W-1:0]          last_addr;
  logic [efa_pkg::CNT_W-1:0]  last_val;

  logic [efa_pkg::CNT_W-1:0]  cur;
  logic [efa_pkg::CNT_W-1:0]  new_val;
  logic                       wr_item;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [efa_pkg::CNT_W-1:0]  wr_data;

  assign h_kind = q_head[ADDR_W +: efa_pkg::KIND_W];
  assign h_addr = q_head[ADDR_W-1:0];

  // whole back end freezes while a result waits on a stalled output
  assign adv   = !rsp_valid || !rsp_stall;
  assign q_pop = adv && q_not_empty && !clearing;

  // memory read was issued while the previous item was still writing
  assign cur = (last_v && (last_addr == b1_addr)) ? last_val : rd_data;

  always_comb begin
    case (b1_kind)
      efa_pkg::KIND_ACC: begin
        new_val = (cur == efa_pkg::CNT_MAX) ? cur : cur + 1'b1;
        wr_item = adv && b1_v;
      end
      efa_pkg::KIND_READ: begin
        new_val = '0;
        wr_item = adv && b1_v;
      end
      default: begin
        new_val = '0;
        wr_item = 1'b0;
      end
    endcase
  end

  assign wr_en   = clearing || wr_item;
  assign wr_addr = clearing ? clr_addr : b1_addr;
  assign wr_data = clearing ? '0 : new_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      counts[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data <= counts[h_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b1_v      <= 1'b0;
      last_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      if (adv) begin
        b1_v      <= q_pop;
        last_v    <= wr_item;
        rsp_valid <= b1_v && (b1_kind != efa_pkg::KIND_ACC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_kind <= h_kind;
      b1_addr <= h_addr;
    end
    if (adv) begin
      pixel_count <= (b1_kind == efa_pkg::KIND_READ) ? cur : '0;
      last_addr   <= b1_addr;
      last_val    <= new_val;
    end
  end

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("queue popped during clear pass");

  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(b1_v) && ($past(b1_kind) != efa_pkg::KIND_ACC)))
    else $error("result raised without a read item");

endmodule

@@ hdl/event_frame_accumulator.sv @@
// Channel  Handshake              Payload
// req      req_valid / req_stall  opcode, row, col, timestamp
// rsp      rsp_valid / rsp_stall  pixel_count
// cfg      cfg_write              cfg_index, cfg_data
//
// Sustains one item per cycle while req_stall is low and rsp is not stalled;
// the count memory's single read-modify-write per cycle (with forwarding of
// the last write) sets that rate. From req accept to pixel_count an item
// passes the 7 front stages, the queue, the memory read and the update stage.
// After reset a clear pass zeroes all MAX_ROWS*MAX_COLS words of the count
// memory; req_stall stays high until it ends.
// req_stall rises when queued plus in-flight items reach 16; a stalled rsp
// freezes the back end while the queue keeps filling.
module event_frame_accumulator #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              opcode,
  input  logic [efa_pkg::POS_W-1:0]         row,
  input  logic [efa_pkg::POS_W-1:0]         col,
  input  logic [efa_pkg::TS_W-1:0]          timestamp,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [efa_pkg::CNT_W-1:0]         pixel_count,
  input  logic                              cfg_write,
  input  logic [efa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [efa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int ENTRY_W = efa_pkg::KIND_W + ADDR_W;

  efa_pkg::cfg_t cfg;

  logic                           clearing;
  logic [efa_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic                           push;
  logic [ENTRY_W-1:0]             push_data;
  logic                           pop;
  logic [ENTRY_W-1:0]             head;
  logic                           not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rows    <= efa_pkg::NUM_ROWS_RST;
      cfg.num_cols    <= efa_pkg::NUM_COLS_RST;
      cfg.slice_start <= '0;
      cfg.slice_width <= efa_pkg::SLICE_WIDTH_RST;
      cfg.drift_row   <= '0;
      cfg.drift_col   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        efa_pkg::REG_NUM_ROWS:    cfg.num_rows    <= cfg_data[efa_pkg::DIM_W-1:0];
        efa_pkg::REG_NUM_COLS:    cfg.num_cols    <= cfg_data[efa_pkg::DIM_W-1:0];
        efa_pkg::REG_SLICE_START: cfg.slice_start <= cfg_data[efa_pkg::TS_W-1:0];
        efa_pkg::REG_SLICE_WIDTH: cfg.slice_width <= cfg_data[efa_pkg::TS_W-1:0];
        efa_pkg::REG_DRIFT_ROW:   cfg.drift_row   <= cfg_data[efa_pkg::DRIFT_W-1:0];
        efa_pkg::REG_DRIFT_COL:   cfg.drift_col   <= cfg_data[efa_pkg::DRIFT_W-1:0];
        default: ;
      endcase
    end
  end

  efa_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .opcode     (opcode),
    .row        (row),
    .col        (col),
    .timestamp  (timestamp),
    .clearing   (clearing),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  efa_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (fifo_count)
  );

  efa_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .clearing    (clearing),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .pixel_count (pixel_count)
  );

endmodule

@@ tb/efa_frame_checker.sv @@
`timescale 1ns / 1ps

module efa_frame_checker #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic                           opcode,
  input  logic [efa_pkg::POS_W-1:0]      row,
  input  logic [efa_pkg::POS_W-1:0]      col,
  input  logic [efa_pkg::TS_W-1:0]       timestamp,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  logic [efa_pkg::CNT_W-1:0]      pixel_count,
  input  logic                           cfg_write,
  input  logic [efa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efa_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             binned_count,
  output int                             read_count
);
  import efa_pkg::*;

  // 10000 ns per drift unit times 2^16 fraction
  localparam logic signed [95:0] SHIFT_DEN = 96'sd655360000;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  logic [CNT_W-1:0] hist [STORE_DEPTH];
  logic [CNT_W-1:0] expected_counts [$];
  cfg_t             cfg;
  logic [TS_W:0]    win_end;
  logic [POS_W-1:0] row_s, col_s;
  logic [DIM_W-1:0] row_lim, col_lim;
  logic [CNT_W-1:0] want;
  int               addr;
  int               n_fail = 0;
  int               n_binned = 0;
  int               n_read = 0;

  assign fail_count   = n_fail;
  assign binned_count = n_binned;
  assign read_count   = n_read;

  // Move one coordinate against the drift, truncating toward zero.
  // Returns 0 when the shifted position falls outside [0, lim).
  function automatic bit shift_pos(input logic [POS_W-1:0] pos,
                                   input logic [TS_W-1:0] dt,
                                   input logic [DRIFT_W-1:0] drift,
                                   input logic [DIM_W-1:0] lim,
                                   output logic [POS_W-1:0] res);
    logic signed [95:0] d, mag, prod, num, quo;
    d = $signed({{72{drift[DRIFT_W-1]}}, drift});
    mag = (d < 0) ? -d : d;
    prod = '0;
    res = '0;
    if (mag != 0) begin
      // shift too large to matter: always out of range
      if ($signed({48'd0, dt}) > (96'sd1 <<< 62) / mag) return 1'b0;
      prod = $signed({48'd0, dt}) * mag;
      if (d < 0) prod = -prod;
    end
    num = $signed({87'd0, pos}) * SHIFT_DEN - prod;
    quo = num / SHIFT_DEN;
    if (quo < 0 || quo >= $signed({86'd0, lim})) return 1'b0;
    res = quo[POS_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_fail++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) hist[i] = '0;
      cfg.num_rows    = NUM_ROWS_RST;
      cfg.num_cols    = NUM_COLS_RST;
      cfg.slice_start = '0;
      cfg.slice_width = SLICE_WIDTH_RST;
      cfg.drift_row   = '0;
      cfg.drift_col   = '0;
      expected_counts.delete();
    end else begin
      // results first, so a read taken this cycle cannot mask a stray result
      if (rsp_valid && !rsp_stall) begin
        if (expected_counts.size() == 0)
          report_mismatch($sformatf("pixel_count %0d with no read pending", pixel_count));
        else begin
          want = expected_counts.pop_front();
          if (pixel_count !== want)
            report_mismatch($sformatf("pixel_count %0d, expected %0d", pixel_count, want));
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_NUM_ROWS:    cfg.num_rows    = cfg_data[DIM_W-1:0];
          REG_NUM_COLS:    cfg.num_cols    = cfg_data[DIM_W-1:0];
          REG_SLICE_START: cfg.slice_start = cfg_data[TS_W-1:0];
          REG_SLICE_WIDTH: cfg.slice_width = cfg_data[TS_W-1:0];
          REG_DRIFT_ROW:   cfg.drift_row   = cfg_data[DRIFT_W-1:0];
          REG_DRIFT_COL:   cfg.drift_col   = cfg_data[DRIFT_W-1:0];
          default: ;
        endcase
      end

      if (req_valid && !req_stall) begin
        if (opcode == OP_READ) begin
          if (int'(row) < MAX_ROWS && int'(col) < MAX_COLS) begin
            addr = int'(row) * MAX_COLS + int'(col);
            expected_counts.push_back(hist[addr]);
            hist[addr] = '0;
          end else
            expected_counts.push_back('0);
          n_read++;
        end else begin
          win_end = {1'b0, cfg.slice_start} + {1'b0, cfg.slice_width};
          row_lim = (int'(cfg.num_rows) < MAX_ROWS) ? cfg.num_rows : DIM_W'(MAX_ROWS);
          col_lim = (int'(cfg.num_cols) < MAX_COLS) ? cfg.num_cols : DIM_W'(MAX_COLS);
          if (timestamp > cfg.slice_start && {1'b0, timestamp} <= win_end &&
              shift_pos(row, timestamp - cfg.slice_start, cfg.drift_row, row_lim, row_s) &&
              shift_pos(col, timestamp - cfg.slice_start, cfg.drift_col, col_lim, col_s)) begin
            addr = int'(row_s) * MAX_COLS + int'(col_s);
            if (hist[addr] != CNT_MAX) hist[addr] = hist[addr] + 1'b1;
            n_binned++;
          end
        end
      end
    end
    pending <= expected_counts.size();
  end

endmodule

@@ tb/tb_event_frame_accumulator.sv @@
`timescale 1ns / 1ps

module tb_event_frame_accumulator;
  import efa_pkg::*;

  localparam int MAX_ROWS = 512;
  localparam int MAX_COLS = 512;
  localparam logic OP_ACC = 1'b0;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  logic                  opcode;
  logic [POS_W-1:0]      row;
  logic [POS_W-1:0]      col;
  logic [TS_W-1:0]       timestamp;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic [CNT_W-1:0]      pixel_count;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit hold_rsp = 1'b0;
  bit rsp_calm = 1'b0;
  bit send_calm = 1'b0;

  // sender's copy of the current window and frame size
  logic [DIM_W-1:0] set_rows;
  logic [TS_W-1:0]  set_start, set_width;
  logic [POS_W-1:0] hot_row, hot_col;
  int               n_sent = 0;
  int               n_settings = 0;

  int fail_count, pending, binned_count, read_count;

  event_frame_accumulator #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .row(row), .col(col), .timestamp(timestamp),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .pixel_count(pixel_count),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  efa_frame_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) i_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .row(row), .col(col), .timestamp(timestamp),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .pixel_count(pixel_count),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .binned_count(binned_count), .read_count(read_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d read results outstanding", pending);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [TS_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TS_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // mostly small drifts so shifts stay near the frame, now and then any value
  function automatic logic [DRIFT_W-1:0] rand_drift();
    int span;
    if ($urandom_range(0, 4) == 0) return DRIFT_W'($urandom);
    span = 1 << $urandom_range(6, 18);
    return DRIFT_W'($urandom_range(0, 2 * span) - span);
  endfunction

  // receive side: random stalls, calm stretches, one long hold on request
  initial begin
    int r, n;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_stall = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        rsp_stall = 1'b0;
        hold_rsp = 1'b0;
      end else if (rsp_calm)
        rsp_stall = 1'b0;
      else begin
        r = $urandom_range(0, 99);
        if (r < 70)
          rsp_stall = 1'b0;
        else begin
          rsp_stall = 1'b1;
          n = (r < 90) ? $urandom_range(1, 3) :
              (r < 98) ? $urandom_range(4, 10) : $urandom_range(15, 40);
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic op, input logic [POS_W-1:0] r, c,
                           input logic [TS_W-1:0] ts);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    opcode    = op;
    row       = r;
    col       = c;
    timestamp = ts;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // accumulates give no result, so wait out the pipeline after the last read
  task automatic settle();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [DIM_W-1:0] rows, cols,
                               input logic [TS_W-1:0] start, width,
                               input logic [DRIFT_W-1:0] drow, dcol);
    int lim;
    settle();
    write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_NUM_COLS, CFG_DATA_W'(cols));
    write_reg(REG_SLICE_START, CFG_DATA_W'(start));
    write_reg(REG_SLICE_WIDTH, CFG_DATA_W'(width));
    write_reg(REG_DRIFT_ROW, CFG_DATA_W'(drow));
    write_reg(REG_DRIFT_COL, CFG_DATA_W'(dcol));
    set_rows  = rows;
    set_start = start;
    set_width = width;
    lim = (int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows);
    hot_row = (lim == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, lim - 1));
    lim = (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
    hot_col = (lim == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, lim - 1));
    n_settings++;
  endtask

  task automatic random_item(input int read_pct, input int hot_pct);
    int pick;
    logic [POS_W-1:0] r, c;
    logic [TS_W-1:0]  ts, span;
    pick = $urandom_range(0, 99);
    if (pick < read_pct) begin
      if ($urandom_range(0, 9) < 7) begin
        r = hot_row + POS_W'($urandom_range(0, 6) - 3);
        c = hot_col + POS_W'($urandom_range(0, 6) - 3);
      end else begin
        r = POS_W'($urandom);
        c = POS_W'($urandom);
      end
      send_item(OP_READ, r, c, rand48());
    end else if (pick < read_pct + 4)
      send_item(OP_ACC, POS_W'($urandom), POS_W'($urandom), rand48());
    else begin
      pick = $urandom_range(0, 99);
      if (pick < hot_pct) begin
        r = hot_row;
        c = hot_col;
      end else if (pick < 96) begin
        r = hot_row + POS_W'($urandom_range(0, 14) - 7);
        c = hot_col + POS_W'($urandom_range(0, 14) - 7);
      end else begin
        r = POS_W'($urandom);
        c = POS_W'($urandom);
      end
      span = (set_width < TS_MAX - set_start) ? set_width : TS_MAX - set_start;
      pick = $urandom_range(0, 99);
      if (span != 0 && pick < 5)
        ts = pick[0] ? set_start : set_start + span;   // window edges
      else if (span == 0 || pick < 15) begin
        if (set_start != 0 && set_start != TS_MAX && pick[0])
          ts = rand48() % (set_start + 1);
        else
          ts = rand48();
      end else
        ts = set_start + 1 + (rand48() >> $urandom_range(0, TS_W - 1)) % span;
      send_item(OP_ACC, r, c, ts);
    end
  endtask

  initial begin
    int k, n_items, read_pct, hot_pct;
    rst       = 1'b1;
    req_valid = 1'b0;
    opcode    = OP_ACC;
    row       = '0;
    col       = '0;
    timestamp = '0;
    cfg_write = 1'b0;
    cfg_index = REG_NUM_ROWS;
    cfg_data  = '0;
    set_rows  = NUM_ROWS_RST;
    set_start = '0;
    set_width = SLICE_WIDTH_RST;
    hot_row   = '0;
    hot_col   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: window edges and frame bounds
    send_item(OP_READ, 9'd0, 9'd0, '0);
    send_item(OP_ACC, 9'd0, 9'd0, 48'd0);
    send_item(OP_ACC, 9'd0, 9'd0, 48'd1);
    send_item(OP_ACC, 9'd0, 9'd0, 48'd10000000);
    send_item(OP_ACC, 9'd0, 9'd0, 48'd10000001);
    send_item(OP_ACC, 9'd0, 9'd0, TS_MAX);
    send_item(OP_READ, 9'd0, 9'd0, TS_MAX);
    send_item(OP_ACC, 9'd239, 9'd179, 48'd5);
    send_item(OP_ACC, 9'd240, 9'd0, 48'd5);
    send_item(OP_ACC, 9'd0, 9'd180, 48'd5);
    send_item(OP_ACC, 9'd511, 9'd511, 48'd5);
    send_item(OP_READ, 9'd239, 9'd179, '0);
    send_item(OP_READ, 9'd240, 9'd0, '0);
    send_item(OP_READ, 9'd511, 9'd511, '0);

    // one pixel per 10 us: half-pixel shifts truncate to zero, full ones move
    apply_setting(10'd512, 10'd512, 48'd1000, 48'd1000000000, 24'h010000, 24'hFF0000);
    send_item(OP_ACC, 9'd0, 9'd0, 48'd6000);
    send_item(OP_ACC, 9'd0, 9'd511, 48'd11000);
    send_item(OP_ACC, 9'd5, 9'd510, 48'd11000);
    send_item(OP_ACC, 9'd5, 9'd511, 48'd11000);
    send_item(OP_READ, 9'd0, 9'd0, '0);
    send_item(OP_READ, 9'd4, 9'd511, '0);

    // extreme drifts: product overflow drops, tiny dt stays put
    apply_setting(10'd512, 10'd512, '0, TS_MAX, 24'h7FFFFF, 24'h800000);
    send_item(OP_ACC, 9'd100, 9'd100, 48'h800000000000);
    send_item(OP_ACC, 9'd0, 9'd0, 48'd1);
    send_item(OP_READ, 9'd0, 9'd0, '0);

    for (int p = 0; p < 8; p++) begin
      send_calm = ($urandom_range(0, 3) == 0);
      rsp_calm  = ($urandom_range(0, 3) == 0);
      read_pct  = 15;
      hot_pct   = 50;
      case (p)
        0: begin
          // one pixel hammered until it saturates
          apply_setting(10'd512, 10'd512, '0, TS_MAX, '0, '0);
          n_items  = 350;
          read_pct = 1;
          hot_pct  = 98;
        end
        1: begin
          apply_setting(10'd1, 10'd1, rand48(), TS_W'($urandom_range(1, 1000000)),
                        rand_drift(), rand_drift());
          n_items = 120;
          hot_pct = 60;
        end
        2: begin
          apply_setting(10'd1023, 10'd1023, TS_MAX - TS_W'($urandom_range(0, 1 << 20)),
                        TS_MAX, 24'h7FFFFF, 24'h800000);
          n_items = 140;
        end
        3: begin
          // zero rows: every event dropped, reads still drain old counts
          apply_setting(10'd0, DIM_W'($urandom_range(1, 1023)),
                        rand48() >> $urandom_range(0, TS_W - 1), rand48(),
                        rand_drift(), rand_drift());
          n_items  = 50;
          read_pct = 25;
        end
        5: begin
          // empty window
          apply_setting(DIM_W'($urandom_range(1, 512)), DIM_W'($urandom_range(1, 512)),
                        rand48(), '0, rand_drift(), rand_drift());
          n_items  = 40;
          read_pct = 20;
        end
        default: begin
          apply_setting(DIM_W'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 1023 : 512)),
                        DIM_W'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 1023 : 512)),
                        rand48() >> $urandom_range(0, TS_W - 1),
                        rand48() >> $urandom_range(0, TS_W - 1),
                        rand_drift(), rand_drift());
          n_items = (p == 4) ? 140 : (p == 6) ? 200 : 240;
        end
      endcase
      for (k = 0; k < n_items; k++) begin
        if (p == 4 && k == 30) begin
          // hold results back while reads keep coming, so the input backs up
          hold_rsp  = 1'b1;
          send_calm = 1'b1;
          repeat (40)
            send_item(OP_READ, hot_row + POS_W'($urandom_range(0, 2)), hot_col, rand48());
          send_calm = 1'b0;
        end
        random_item(read_pct, hot_pct);
      end
      if (p == 0) send_item(OP_READ, hot_row, hot_col, rand48());
    end

    req_valid = 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d items over %0d register settings; %0d reads checked, %0d events binned",
             n_sent, n_settings, read_count, binned_count);
    $display("Included window edges, frame bounds, drift shifts, saturation, a long result hold");
    if (pending != 0) $display("%0d read results never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ event_frame_accumulator.f @@
hdl/efa_pkg.sv
hdl/efa_queue.sv
hdl/efa_front.sv
hdl/efa_back.sv
hdl/event_frame_accumulator.sv
tb/efa_frame_checker.sv
tb/tb_event_frame_accumulator.sv
